### rtl/mstsel_pkg.sv
// Package: widths, forest entry and write port types for the MST edge selector.
`default_nettype none
package mstsel_pkg;

  localparam int MAX_NODES = 1024;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int SIZE_W    = $clog2(MAX_NODES) + 1;
  localparam int NCNT_W    = 11;
  localparam int WEIGHT_W  = 32;
  localparam int COST_W    = 42;

  typedef logic [NODE_W-1:0]   node_t;
  typedef logic [SIZE_W-1:0]   size_t;
  typedef logic [NCNT_W-1:0]   ncnt_t;
  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [COST_W-1:0]   cost_t;

  typedef struct packed {
    node_t parent;
    size_t size;
  } entry_t;

  typedef struct packed {
    logic   en;
    node_t  addr;
    entry_t data;
  } wr_t;

endpackage
`default_nettype wire

### rtl/mst_edge_selector_union_find.sv
// Top level: Kruskal edge selector over a union-by-size forest held in one RAM.
//
//   channel   | handshake           | word
//   ----------+---------------------+---------------------------------------------
//   input     | in_valid / in_ready | node_a, node_b, edge_weight, last_edge
//   output    | out_valid/out_ready | accepted, tree_cost, edges_in_tree, tree_complete
//   config    | cfg_we              | cfg_data (node_count)
//
// One edge at a time. Steps per edge: accept, root walk reads for node_a and then node_b,
// merge writes to both roots when accepted, then the result.
// A rejected endpoint or full tree skips the walks.
// After reset and after a last_edge word the forest RAM is swept, one entry per cycle,
// over all 1024 entries with in_ready low. A stalled output holds the result; in_ready
// returns once the result register is loaded, or after the sweep for a last_edge word.
`default_nettype none
module mst_edge_selector_union_find (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire mstsel_pkg::ncnt_t   cfg_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire mstsel_pkg::node_t   node_a,
  input  wire mstsel_pkg::node_t   node_b,
  input  wire mstsel_pkg::weight_t edge_weight,
  input  wire logic                last_edge,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     accepted,
  output mstsel_pkg::cost_t        tree_cost,
  output mstsel_pkg::node_t        edges_in_tree,
  output logic                     tree_complete
);
  import mstsel_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_WALK_A, ST_WALK_B, ST_MERGE1, ST_MERGE2, ST_RESULT
  } state_t;

  state_t  state;
  ncnt_t   node_count;
  ncnt_t   n_eff;
  node_t   n_last;
  node_t   clr_idx;
  node_t   b_r, cur, ra, lo, hi;
  size_t   sa, lo_size, sum;
  weight_t w_r;
  logic    last_r, acc_r;
  cost_t   cost;
  node_t   cnt;
  logic    in_ok;

  node_t   raddr;
  wr_t     wr;
  entry_t  rdata;

  mstsel_forest_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    if (node_count == '0) begin
      n_eff = ncnt_t'(1);
    end else if (node_count > ncnt_t'(MAX_NODES)) begin
      n_eff = ncnt_t'(MAX_NODES);
    end else begin
      n_eff = node_count;
    end
    n_last = node_t'(n_eff - ncnt_t'(1));
    in_ok  = ({1'b0, node_a} < n_eff) && ({1'b0, node_b} < n_eff) && (cnt < n_last);
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    case (state)
      ST_IDLE:   raddr = node_a;
      ST_WALK_A: raddr = (rdata.parent == cur) ? b_r : rdata.parent;
      ST_WALK_B: raddr = rdata.parent;
      default:   raddr = cur;
    endcase
    wr = '0;
    case (state)
      ST_CLEAR: begin
        wr.en   = 1'b1;
        wr.addr = clr_idx;
        wr.data = '{parent: clr_idx, size: size_t'(1)};
      end
      ST_MERGE1: begin
        wr.en   = 1'b1;
        wr.addr = lo;
        wr.data = '{parent: hi, size: lo_size};
      end
      ST_MERGE2: begin
        wr.en   = 1'b1;
        wr.addr = hi;
        wr.data = '{parent: hi, size: sum};
      end
      default: wr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    cur <= raddr;
    if (rst) begin
      state      <= ST_CLEAR;
      node_count <= ncnt_t'(MAX_NODES);
      clr_idx    <= '0;
      cost       <= '0;
      cnt        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_count <= cfg_data;
      end
      if (out_valid && out_ready && state != ST_RESULT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + node_t'(1);
          if (clr_idx == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            b_r    <= node_b;
            w_r    <= edge_weight;
            last_r <= last_edge;
            acc_r  <= 1'b0;
            state  <= in_ok ? ST_WALK_A : ST_RESULT;
          end
        end
        ST_WALK_A: begin
          if (rdata.parent == cur) begin
            ra    <= cur;
            sa    <= rdata.size;
            state <= ST_WALK_B;
          end
        end
        ST_WALK_B: begin
          if (rdata.parent == cur) begin
            if (cur == ra) begin
              state <= ST_RESULT;
            end else begin
              if (sa < rdata.size) begin
                lo      <= ra;
                lo_size <= sa;
                hi      <= cur;
              end else begin
                lo      <= cur;
                lo_size <= rdata.size;
                hi      <= ra;
              end
              sum   <= sa + rdata.size;
              acc_r <= 1'b1;
              cost  <= cost + cost_t'(w_r);
              cnt   <= cnt + node_t'(1);
              state <= ST_MERGE1;
            end
          end
        end
        ST_MERGE1: state <= ST_MERGE2;
        ST_MERGE2: state <= ST_RESULT;
        ST_RESULT: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            accepted      <= acc_r;
            tree_cost     <= cost;
            edges_in_tree <= cnt;
            tree_complete <= (cnt == n_last);
            if (last_r) begin
              cost    <= '0;
              cnt     <= '0;
              clr_idx <= '0;
              state   <= ST_CLEAR;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  a_rise_from_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_RESULT))
    else $error("result word appeared outside the result step");

  a_merge_two_roots: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MERGE1) |=> (wr.en && wr.addr != $past(wr.addr)))
    else $error("merge wrote the same root twice");

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != ST_IDLE))
    else $error("accepted word did not start work");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MERGE1) |-> (cnt == $past(cnt) + node_t'(1)))
    else $error("edge count did not advance on merge");

endmodule
`default_nettype wire

### rtl/mstsel_forest_ram.sv
// Forest memory: one parent link and component size per node, registered read.
`default_nettype none
module mstsel_forest_ram (
  input  wire logic            clk,
  input  wire mstsel_pkg::wr_t wr,
  input  wire mstsel_pkg::node_t raddr,
  output mstsel_pkg::entry_t   rdata
);
  import mstsel_pkg::*;

  entry_t mem [MAX_NODES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
